FILE: rtl/sws_pkg.sv
package sws_pkg;

   localparam int WindowDepthDefault = 64;
   localparam int CountWidth         = 7;
   localparam int SeqWidth           = 32;
   localparam int CsrWidth           = 16;

   localparam logic [6:0]  WindowLimitReset = 7'd64;
   localparam logic [15:0] TimeoutReset     = 16'd50;
   localparam logic [15:0] FastAgeReset     = 16'd100;
   localparam logic [3:0]  FastLimitReset   = 4'd2;

   typedef enum logic [1:0] {
      CMD_SEND = 2'd0,
      CMD_ACK  = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_LIMIT = 2'd0,
      CSR_TIMEOUT      = 2'd1,
      CSR_FAST_AGE     = 2'd2,
      CSR_FAST_LIMIT   = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      KIND_SENT    = 3'd0,
      KIND_REFUSED = 3'd1,
      KIND_FAST    = 3'd2,
      KIND_TIMEOUT = 3'd3,
      KIND_NONE    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_SACK,
      ST_POP_RD,
      ST_POP_EV,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/sack_window_sender_unit.sv
// Transmit scoreboard of a selective-repeat sender. Raise start with a command
// while busy is low. A send never leaves idle: its single result appears on
// the next cycle and busy stays low, so sends may follow every cycle. An ack
// marks the cumulatively acked entries one a cycle (up to the window count),
// marks the selective entry, pops acked head entries, then, if the selective
// ack is in the window and the fast limit is nonzero, scans for fast retransmits;
// a tick scans the window until it meets a young unacked packet. Each entry
// takes a read and an evaluate state, as both memories have a registered read port.
// Results come as single-cycle rsp_valid beats that cannot be held off; rsp_last
// marks the final beat of a command, after which busy is already low.
module sack_window_sender_unit
   import sws_pkg::*;
#(
   parameter int WINDOW_DEPTH = WindowDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_command,
   input  logic [SeqWidth-1:0]   req_ack_seq,
   input  logic [SeqWidth-1:0]   req_sack_seq,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [SeqWidth-1:0]   rsp_seq,
   output logic [CountWidth-1:0] rsp_window_count,
   output logic [SeqWidth-1:0]   rsp_oldest_seq,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [CsrWidth-1:0]   csr_write_data
);

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(WINDOW_DEPTH);

   function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] h,
                                             input logic [CountWidth-1:0] i);
      logic [CountWidth:0] s;
      begin
         s = (CountWidth+1)'(h) + (CountWidth+1)'(i);
         if (s >= (CountWidth+1)'(WINDOW_DEPTH)) begin
            s = s - (CountWidth+1)'(WINDOW_DEPTH);
         end
         return s[AW-1:0];
      end
   endfunction

   // config
   logic [6:0]  win_limit_ff;
   logic [15:0] timeout_ff;
   logic [15:0] fast_age_ff;
   logic [3:0]  fast_limit_ff;

   // control
   state_type             state_ff, state_in;
   logic [SeqWidth-1:0]   next_ff, next_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SeqWidth-1:0]   time_ff, time_in;
   kind_type              kind_ff, kind_in;
   logic [CountWidth-1:0] idx_ff, idx_in;
   logic [CountWidth-1:0] n_ff, n_in;
   logic [CountWidth-1:0] sidx_ff, sidx_in;
   logic                  sack_ok_ff, sack_ok_in;
   logic [CountWidth-1:0] lim_ff, lim_in;
   logic                  fast_ff, fast_in;
   logic [3:0]            budget_ff, budget_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic                  pend_ff, pend_in;
   logic [SeqWidth-1:0]   pend_seq_ff, pend_seq_in;

   // result beat
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [SeqWidth-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic [SeqWidth-1:0]   rsp_base_ff, rsp_base_in;
   logic                  rsp_last_ff, rsp_last_in;

   // memories
   logic                mark_mem [WINDOW_DEPTH];
   logic [SeqWidth-1:0] time_mem [WINDOW_DEPTH];
   logic                mark_q;
   logic [SeqWidth-1:0] time_q;
   logic                mark_we, mark_wd, time_we, rd_en;
   logic [AW-1:0]       mark_wa, time_wa, rd_addr;

   logic [SeqWidth-1:0]   base, diff_ack, diff_sack, age;
   logic [CountWidth-1:0] win_lim, scan_lim;
   logic                  hit, stop;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_limit_ff  <= WindowLimitReset;
         timeout_ff    <= TimeoutReset;
         fast_age_ff   <= FastAgeReset;
         fast_limit_ff <= FastLimitReset;
      end else if (csr_write_enable) begin
         unique case (csr_type'(csr_index))
            CSR_WINDOW_LIMIT: win_limit_ff  <= csr_write_data[6:0];
            CSR_TIMEOUT:      timeout_ff    <= csr_write_data;
            CSR_FAST_AGE:     fast_age_ff   <= csr_write_data;
            CSR_FAST_LIMIT:   fast_limit_ff <= csr_write_data[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (time_we) begin
         time_mem[time_wa] <= time_ff;
      end
      if (rd_en) begin
         mark_q <= mark_mem[rd_addr];
         time_q <= time_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         time_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      sidx_ff      <= sidx_in;
      sack_ok_ff   <= sack_ok_in;
      lim_ff       <= lim_in;
      fast_ff      <= fast_in;
      budget_ff    <= budget_in;
      addr_ff      <= addr_in;
      pend_seq_ff  <= pend_seq_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_count_ff <= rsp_count_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign base      = next_ff - SeqWidth'(count_ff);
   assign diff_ack  = req_ack_seq - base;
   assign diff_sack = req_sack_seq - base;
   assign age       = time_ff - time_q;
   assign win_lim   = (win_limit_ff > DepthCount) ? DepthCount : win_limit_ff;
   assign scan_lim  = fast_ff ? lim_ff : count_ff;

   always_comb begin
      hit  = 1'b0;
      stop = 1'b0;
      if (!mark_q) begin
         if (fast_ff) begin
            hit = age > SeqWidth'(fast_age_ff);
         end else if (age > SeqWidth'(timeout_ff)) begin
            hit = 1'b1;
         end else begin
            stop = age < SeqWidth'(timeout_ff[15:1]);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      next_in      = next_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      sidx_in      = sidx_ff;
      sack_ok_in   = sack_ok_ff;
      lim_in       = lim_ff;
      fast_in      = fast_ff;
      budget_in    = budget_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      pend_seq_in  = pend_seq_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_count_in = count_ff;
      rsp_base_in  = base;
      rsp_last_in  = 1'b0;
      mark_we      = 1'b0;
      mark_wa      = slot_at(head_ff, idx_ff);
      mark_wd      = 1'b1;
      time_we      = 1'b0;
      time_wa      = addr_ff;
      rd_en        = 1'b0;
      rd_addr      = slot_at(head_ff, idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in  = '0;
               pend_in = 1'b0;
               unique case (req_command)
                  CMD_SEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_seq_in   = next_ff;
                     if (count_ff < win_lim) begin
                        mark_we      = 1'b1;
                        mark_wa      = slot_at(head_ff, count_ff);
                        mark_wd      = 1'b0;
                        time_we      = 1'b1;
                        time_wa      = slot_at(head_ff, count_ff);
                        count_in     = count_ff + 1'b1;
                        next_in      = next_ff + 1'b1;
                        rsp_kind_in  = KIND_SENT;
                        rsp_count_in = count_ff + 1'b1;
                     end else begin
                        rsp_kind_in  = KIND_REFUSED;
                     end
                  end
                  CMD_ACK: begin
                     kind_in    = KIND_FAST;
                     n_in       = '0;
                     if (diff_ack != '0 && !diff_ack[SeqWidth-1]) begin
                        n_in = (diff_ack < SeqWidth'(count_ff)) ?
                               diff_ack[CountWidth-1:0] : count_ff;
                     end
                     sidx_in    = diff_sack[CountWidth-1:0];
                     sack_ok_in = diff_sack < SeqWidth'(count_ff);
                     state_in   = (count_ff == '0) ? ST_DONE : ST_MARK;
                  end
                  CMD_TICK: begin
                     kind_in  = KIND_TIMEOUT;
                     time_in  = time_ff + 1'b1;
                     fast_in  = 1'b0;
                     state_in = (count_ff == '0) ? ST_DONE : ST_SCAN_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MARK: begin
            if (idx_ff < n_ff) begin
               mark_we = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else begin
               state_in = ST_SACK;
            end
         end
         ST_SACK: begin
            mark_we  = sack_ok_ff;
            mark_wa  = slot_at(head_ff, sidx_ff);
            lim_in   = sidx_ff;
            state_in = ST_POP_RD;
         end
         ST_POP_RD: begin
            idx_in    = '0;
            fast_in   = 1'b1;
            budget_in = fast_limit_ff;
            if (count_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_POP_EV;
            end else begin
               state_in = (sack_ok_ff && fast_limit_ff != '0) ? ST_SCAN_RD : ST_DONE;
            end
         end
         ST_POP_EV: begin
            if (mark_q) begin
               head_in  = slot_at(head_ff, CountWidth'(1));
               count_in = count_ff - 1'b1;
               if (lim_ff != '0) begin
                  lim_in = lim_ff - 1'b1;
               end
               state_in = ST_POP_RD;
            end else begin
               state_in = (sack_ok_ff && fast_limit_ff != '0) ? ST_SCAN_RD : ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff >= scan_lim || (fast_ff && budget_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               addr_in  = slot_at(head_ff, idx_ff);
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            if (hit) begin
               time_we      = 1'b1;
               rsp_valid_in = pend_ff;
               rsp_kind_in  = kind_ff;
               rsp_seq_in   = pend_seq_ff;
               pend_in      = 1'b1;
               pend_seq_in  = base + SeqWidth'(idx_ff);
               budget_in    = budget_ff - 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = stop ? ST_DONE : ST_SCAN_RD;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_kind_in  = pend_ff ? kind_ff : KIND_NONE;
            rsp_seq_in   = pend_ff ? pend_seq_ff : '0;
            pend_in      = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_seq          = rsp_seq_ff;
   assign rsp_window_count = rsp_count_ff;
   assign rsp_oldest_seq   = rsp_base_ff;
   assign rsp_last         = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("window count beyond depth");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final beat while still busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final beat after command done");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted command left no trace");

endmodule
